[design/segpc_pkg.sv]
`default_nettype none
package segpc_pkg;
  localparam int COORD_W        = 32;
  localparam int GAP_W          = 33;
  localparam int PARAM_FRAC_DEF = 24;
  localparam int MUL_CHUNK      = 17;

  typedef logic signed [COORD_W-1:0] coord_t;
endpackage
`default_nettype wire

[design/segment_pair_closest_distance.sv]
`default_nettype none
// Closest points between two 3D segments and their rounded distance, one
// segment pair per clock while the pipeline is not held. The pipeline depth is
// set by the three chained PARAM_FRAC_BITS+1 stage dividers for s, t and the
// refined s, plus the multi-stage wide multipliers and the bit-per-stage
// square root.
// The whole pipeline holds while a result waits under out_stall, so
// in_stall follows out_valid & out_stall.
module segment_pair_closest_distance #(
  parameter int PARAM_FRAC_BITS = segpc_pkg::PARAM_FRAC_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire segpc_pkg::coord_t in_first_start_x,
  input  wire segpc_pkg::coord_t in_first_start_y,
  input  wire segpc_pkg::coord_t in_first_start_z,
  input  wire segpc_pkg::coord_t in_first_end_x,
  input  wire segpc_pkg::coord_t in_first_end_y,
  input  wire segpc_pkg::coord_t in_first_end_z,
  input  wire segpc_pkg::coord_t in_second_start_x,
  input  wire segpc_pkg::coord_t in_second_start_y,
  input  wire segpc_pkg::coord_t in_second_start_z,
  input  wire segpc_pkg::coord_t in_second_end_x,
  input  wire segpc_pkg::coord_t in_second_end_y,
  input  wire segpc_pkg::coord_t in_second_end_z,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [segpc_pkg::GAP_W-1:0] out_gap_length,
  output segpc_pkg::coord_t      out_first_near_x,
  output segpc_pkg::coord_t      out_first_near_y,
  output segpc_pkg::coord_t      out_first_near_z,
  output segpc_pkg::coord_t      out_second_near_x,
  output segpc_pkg::coord_t      out_second_near_y,
  output segpc_pkg::coord_t      out_second_near_z
);
  import segpc_pkg::*;

  localparam int P     = PARAM_FRAC_BITS;
  localparam int DW    = COORD_W + 1;
  localparam int SQW   = 2 * DW;
  localparam int DOTW  = SQW + 2;
  localparam int WIDEW = 2 * DOTW;
  localparam int PRW   = P + 1;
  localparam int SPW   = PRW + 1;
  localparam int NUMW  = WIDEW + P;
  localparam int NTW   = DOTW + P + 3;
  localparam int NPW   = SPW + DW;
  localparam int SUMW  = SQW + 2;
  localparam int LM1   = (DOTW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LM2   = (SPW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LDIV  = P + 1;
  localparam int LSQ   = (SUMW + 1) / 2 + 1;
  localparam int T1    = 1;
  localparam int T3    = 3;
  localparam int T4    = T3 + LM1 + 1;
  localparam int TD1   = T4 + LDIV;
  localparam int TM2   = TD1 + LM2;
  localparam int T5    = TM2 + 1;
  localparam int TD2   = T5 + LDIV;
  localparam int TM3   = TD2 + LM2;
  localparam int T6    = TM3 + 1;
  localparam int TD3   = T6 + LDIV;
  localparam int TN2   = TD3 + 2;
  localparam int TN4   = TN2 + 2;
  localparam int TOUT  = TN4 + LSQ;
  localparam int PTW   = 6 * COORD_W + 6 * DW;
  localparam logic signed [NPW-1:0] HALF = NPW'(1) <<< (P - 1);

  logic en;
  logic [TOUT:1] vld_r;

  assign en        = !(vld_r[TOUT] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[TOUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOUT-1:1], in_valid};
    end
  end

  // stage 1: differences
  coord_t p0_in [3], p1_in [3], q0_in [3], q1_in [3];
  assign p0_in[0] = in_first_start_x;
  assign p0_in[1] = in_first_start_y;
  assign p0_in[2] = in_first_start_z;
  assign p1_in[0] = in_first_end_x;
  assign p1_in[1] = in_first_end_y;
  assign p1_in[2] = in_first_end_z;
  assign q0_in[0] = in_second_start_x;
  assign q0_in[1] = in_second_start_y;
  assign q0_in[2] = in_second_start_z;
  assign q1_in[0] = in_second_end_x;
  assign q1_in[1] = in_second_end_y;
  assign q1_in[2] = in_second_end_z;

  coord_t p0_r [3], q0_r [3];
  logic signed [DW-1:0] u_r [3], v_r [3], w_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= p0_in[i];
        q0_r[i] <= q0_in[i];
        u_r[i]  <= DW'(p1_in[i]) - DW'(p0_in[i]);
        v_r[i]  <= DW'(q1_in[i]) - DW'(q0_in[i]);
        w_r[i]  <= DW'(p0_in[i]) - DW'(q0_in[i]);
      end
    end
  end

  // stages 2-3: dot products a, b, c, d, e
  logic signed [SQW-1:0]  pr_r [5][3];
  logic signed [DOTW-1:0] dot_r [5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[0][i] <= u_r[i] * u_r[i];
        pr_r[1][i] <= u_r[i] * v_r[i];
        pr_r[2][i] <= v_r[i] * v_r[i];
        pr_r[3][i] <= u_r[i] * w_r[i];
        pr_r[4][i] <= v_r[i] * w_r[i];
      end
      for (int k = 0; k < 5; k++) begin
        dot_r[k] <= DOTW'(pr_r[k][0]) + DOTW'(pr_r[k][1]) + DOTW'(pr_r[k][2]);
      end
    end
  end

  // denominator and numerator of s
  logic signed [WIDEW-1:0] ac, bb, be, cd;
  logic signed [WIDEW-1:0] den_r, nums_r;

  segpc_mul #(.AW(DOTW), .BW(DOTW), .CW(MUL_CHUNK)) u_mul_ac (
    .clk(clk), .en(en), .a(dot_r[0]), .b(dot_r[2]), .p(ac));
  segpc_mul #(.AW(DOTW), .BW(DOTW), .CW(MUL_CHUNK)) u_mul_bb (
    .clk(clk), .en(en), .a(dot_r[1]), .b(dot_r[1]), .p(bb));
  segpc_mul #(.AW(DOTW), .BW(DOTW), .CW(MUL_CHUNK)) u_mul_be (
    .clk(clk), .en(en), .a(dot_r[1]), .b(dot_r[4]), .p(be));
  segpc_mul #(.AW(DOTW), .BW(DOTW), .CW(MUL_CHUNK)) u_mul_cd (
    .clk(clk), .en(en), .a(dot_r[2]), .b(dot_r[3]), .p(cd));

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= ac - bb;
      nums_r <= be - cd;
    end
  end

  logic [PRW-1:0] s0_div;
  logic           den_np;
  assign den_np = den_r[WIDEW-1] || (den_r == '0);

  segpc_div #(.NW(NUMW), .DW(WIDEW), .P(P)) u_div_s0 (
    .clk(clk), .en(en), .force_zero(den_np),
    .num(NUMW'(nums_r) <<< P), .den(den_r), .quo(s0_div));

  logic [5*DOTW-1:0] abcde_d1, abcde_d2;
  segpc_dly #(.W(5*DOTW), .D(TD1-T3)) u_dly_k1 (
    .clk(clk), .en(en),
    .d({dot_r[0], dot_r[1], dot_r[2], dot_r[3], dot_r[4]}), .q(abcde_d1));

  logic signed [DOTW-1:0] b_d1;
  assign b_d1 = abcde_d1[3*DOTW +: DOTW];

  // t from s0
  logic signed [DOTW+SPW-1:0] sb;
  segpc_mul #(.AW(DOTW), .BW(SPW), .CW(MUL_CHUNK)) u_mul_sb (
    .clk(clk), .en(en), .a(b_d1), .b(SPW'({1'b0, s0_div})), .p(sb));

  segpc_dly #(.W(5*DOTW), .D(LM2)) u_dly_k2 (
    .clk(clk), .en(en), .d(abcde_d1), .q(abcde_d2));

  logic signed [DOTW-1:0] a_d2, b_d2, c_d2, d_d2, e_d2;
  assign {a_d2, b_d2, c_d2, d_d2, e_d2} = abcde_d2;

  logic signed [NTW-1:0]  numt_r;
  logic signed [DOTW-1:0] a5_r, b5_r, c5_r, d5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      numt_r <= (NTW'(e_d2) <<< P) + NTW'(sb);
      a5_r   <= a_d2;
      b5_r   <= b_d2;
      c5_r   <= c_d2;
      d5_r   <= d_d2;
    end
  end

  logic [PRW-1:0] t_div;
  logic           c_np;
  assign c_np = c5_r[DOTW-1] || (c5_r == '0);

  segpc_div #(.NW(NTW), .DW(DOTW), .P(P)) u_div_t (
    .clk(clk), .en(en), .force_zero(c_np), .num(numt_r), .den(c5_r), .quo(t_div));

  logic [3*DOTW-1:0] abd_d4;
  segpc_dly #(.W(3*DOTW), .D(LDIV)) u_dly_k4 (
    .clk(clk), .en(en), .d({a5_r, b5_r, d5_r}), .q(abd_d4));

  logic signed [DOTW-1:0] a_d4, b_d4, d_d4;
  assign {a_d4, b_d4, d_d4} = abd_d4;

  // refined s from t
  logic signed [DOTW+SPW-1:0] tb;
  segpc_mul #(.AW(DOTW), .BW(SPW), .CW(MUL_CHUNK)) u_mul_tb (
    .clk(clk), .en(en), .a(b_d4), .b(SPW'({1'b0, t_div})), .p(tb));

  logic [2*DOTW-1:0] ad_d5;
  segpc_dly #(.W(2*DOTW), .D(LM2)) u_dly_k5 (
    .clk(clk), .en(en), .d({a_d4, d_d4}), .q(ad_d5));

  logic signed [DOTW-1:0] a_d5, d_d5;
  assign {a_d5, d_d5} = ad_d5;

  logic signed [NTW-1:0]  nsr_r;
  logic signed [DOTW-1:0] a6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nsr_r <= NTW'(tb) - (NTW'(d_d5) <<< P);
      a6_r  <= a_d5;
    end
  end

  logic [PRW-1:0] s_div;
  logic           a_np;
  assign a_np = a6_r[DOTW-1] || (a6_r == '0);

  segpc_div #(.NW(NTW), .DW(DOTW), .P(P)) u_div_s (
    .clk(clk), .en(en), .force_zero(a_np), .num(nsr_r), .den(a6_r), .quo(s_div));

  logic [PRW-1:0] s0_d, t_d;
  logic           a_np_d;

  segpc_dly #(.W(PRW), .D(TD3-TD1)) u_dly_s0 (
    .clk(clk), .en(en), .d(s0_div), .q(s0_d));
  segpc_dly #(.W(PRW), .D(TD3-TD2)) u_dly_t (
    .clk(clk), .en(en), .d(t_div), .q(t_d));
  segpc_dly #(.W(1), .D(LDIV)) u_dly_anp (
    .clk(clk), .en(en), .d(a_np), .q(a_np_d));

  logic [PRW-1:0] s_fin;
  assign s_fin = a_np_d ? s0_d : s_div;

  // bases and deltas
  logic [PTW-1:0] pt_d;
  segpc_dly #(.W(PTW), .D(TD3-T1)) u_dly_pt (
    .clk(clk), .en(en),
    .d({p0_r[0], p0_r[1], p0_r[2], q0_r[0], q0_r[1], q0_r[2],
        u_r[0], u_r[1], u_r[2], v_r[0], v_r[1], v_r[2]}),
    .q(pt_d));

  coord_t pb_d [3], qb_d [3];
  logic signed [DW-1:0] u_d [3], v_d [3];
  assign {pb_d[0], pb_d[1], pb_d[2], qb_d[0], qb_d[1], qb_d[2],
          u_d[0], u_d[1], u_d[2], v_d[0], v_d[1], v_d[2]} = pt_d;

  logic signed [NPW-1:0] prp_r [3], prq_r [3];
  coord_t pb_r [3], qb_r [3];
  coord_t cp_r [3], cq_r [3];
  logic signed [NPW-1:0] rp [3], rq [3];
  logic signed [DW-1:0]  df [3];
  logic [SQW-1:0]  sqd_r [3];
  logic [SUMW-1:0] sum_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rp[i] = (prp_r[i] + HALF) >>> P;
      rq[i] = (prq_r[i] + HALF) >>> P;
      df[i] = DW'(cp_r[i]) - DW'(cq_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prp_r[i] <= $signed(SPW'({1'b0, s_fin})) * u_d[i];
        prq_r[i] <= $signed(SPW'({1'b0, t_d})) * v_d[i];
        pb_r[i]  <= pb_d[i];
        qb_r[i]  <= qb_d[i];
        cp_r[i]  <= pb_r[i] + rp[i][COORD_W-1:0];
        cq_r[i]  <= qb_r[i] + rq[i][COORD_W-1:0];
        sqd_r[i] <= df[i] * df[i];
      end
      sum_r <= SUMW'(sqd_r[0]) + SUMW'(sqd_r[1]) + SUMW'(sqd_r[2]);
    end
  end

  segpc_sqrt #(.SW(SUMW), .OW(GAP_W)) u_sqrt (
    .clk(clk), .en(en), .sq(sum_r), .root(out_gap_length));

  logic [6*COORD_W-1:0] near_d;
  segpc_dly #(.W(6*COORD_W), .D(TOUT-TN2)) u_dly_near (
    .clk(clk), .en(en),
    .d({cp_r[0], cp_r[1], cp_r[2], cq_r[0], cq_r[1], cq_r[2]}), .q(near_d));

  assign {out_first_near_x, out_first_near_y, out_first_near_z,
          out_second_near_x, out_second_near_y, out_second_near_z} = near_d;
endmodule
`default_nettype wire

[design/segpc_dly.sv]
`default_nettype none
module segpc_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < D; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[D-1];
endmodule
`default_nettype wire

[design/segpc_mul.sv]
`default_nettype none
module segpc_mul #(
  parameter int AW = 68,
  parameter int BW = 68,
  parameter int CW = 17
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);
  localparam int NC = (BW + CW - 1) / CW;
  localparam int EW = NC * CW;
  localparam int PW = AW + BW;

  logic signed [AW-1:0] a_r   [NC];
  logic signed [EW-1:0] b_r   [NC];
  logic signed [PW-1:0] acc_r [NC];

  // one CW-bit digit of b per stage, top digit signed
  for (genvar k = 0; k < NC; k++) begin : g_stg
    logic signed [AW-1:0] a_in;
    logic signed [EW-1:0] b_in;
    logic signed [PW-1:0] acc_in;
    logic signed [PW-1:0] pp;
    logic signed [CW:0]   dig;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = EW'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    if (k == NC-1) begin : g_top
      assign dig = {b_in[EW-1], b_in[k*CW +: CW]};
    end else begin : g_low
      assign dig = {1'b0, b_in[k*CW +: CW]};
    end

    assign pp = PW'(a_in) * PW'(dig);

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_in + (pp <<< (k*CW));
      end
    end
  end

  assign p = acc_r[NC-1];
endmodule
`default_nettype wire

[design/segpc_div.sv]
`default_nettype none
module segpc_div #(
  parameter int NW = 160,
  parameter int DW = 136,
  parameter int P  = 24
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic                 force_zero,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic             [P:0]    quo
);
  localparam int XW = ((NW > DW + P) ? NW : DW + P) + 3;
  localparam logic [P:0] ONE = {1'b1, {P{1'b0}}};

  logic [XW-1:0] x_r    [P+1];
  logic [XW-1:0] y_r    [P+1];
  logic [P-1:0]  q_r    [P+1];
  logic          zero_r [P+1];
  logic          full_r [P+1];

  logic [XW-1:0] x0, y0;

  // rounded quotient: floor((2*num + den) / (2*den))
  assign x0 = (XW'($unsigned(num)) << 1) + XW'($unsigned(den));
  assign y0 = XW'($unsigned(den)) << 1;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      q_r[0]    <= '0;
      zero_r[0] <= force_zero || num[NW-1] || (num == '0);
      full_r[0] <= x0 >= (y0 << P);
    end
  end

  for (genvar i = 1; i <= P; i++) begin : g_bit
    localparam int BI = P - i;
    localparam logic [P-1:0] BITM = {{(P-1){1'b0}}, 1'b1} << BI;
    logic [XW-1:0] ys;
    logic          ge;

    assign ys = y_r[i-1] << BI;
    assign ge = x_r[i-1] >= ys;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= ge ? x_r[i-1] - ys : x_r[i-1];
        y_r[i]    <= y_r[i-1];
        q_r[i]    <= ge ? (q_r[i-1] | BITM) : q_r[i-1];
        zero_r[i] <= zero_r[i-1];
        full_r[i] <= full_r[i-1];
      end
    end
  end

  assign quo = zero_r[P] ? '0 : (full_r[P] ? ONE : {1'b0, q_r[P]});
endmodule
`default_nettype wire

[design/segpc_sqrt.sv]
`default_nettype none
module segpc_sqrt #(
  parameter int SW = 68,
  parameter int OW = 33
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [SW-1:0] sq,
  output logic      [OW-1:0] root
);
  localparam int RB = (SW + 1) / 2;
  localparam int TW = 2 * RB + 1;

  logic [TW-1:0] rem_r [RB];
  logic [RB-1:0] rt_r  [RB];
  logic [OW-1:0] out_r;

  for (genvar i = 0; i < RB; i++) begin : g_bit
    localparam int BI = RB - 1 - i;
    localparam logic [RB-1:0] BITM = {{(RB-1){1'b0}}, 1'b1} << BI;
    logic [TW-1:0] rem_in, trial;
    logic [RB-1:0] rt_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = TW'(sq);
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign rt_in  = rt_r[i-1];
    end

    assign trial = (TW'(rt_in) << (BI + 1)) + (TW'(1) << (2 * BI));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_in - trial : rem_in;
        rt_r[i]  <= ge ? (rt_in | BITM) : rt_in;
      end
    end
  end

  logic [RB:0] up, sel;
  assign up  = (RB+1)'(rt_r[RB-1]) + (RB+1)'(1);
  // round half up: sq >= r*r + r + 1
  assign sel = (rem_r[RB-1] >= TW'(up)) ? up : {1'b0, rt_r[RB-1]};

  always_ff @(posedge clk) begin
    if (en) out_r <= OW'(sel);
  end

  assign root = out_r;
endmodule
`default_nettype wire
